### sv/assert_macros.svh
// assertion macros for the great-circle distance block
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCD_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GCD_ASSERT(lbl, prop, msg)
`define GCD_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

### sv/gcd_pkg.sv
// shared constants and elaboration-time arctangent table for the distance block
// no dependencies
`timescale 1ns / 1ps

package gcd_pkg;

  // default vector fraction bits
  localparam int ANGLE_FRAC_BITS = 30;

  // angle format: radians with 58 fraction bits
  localparam int ANG_FRAC = 58;
  localparam int ZW       = 62;

  // field widths
  localparam int LAT_W    = 24;
  localparam int COORD_W  = 26;
  localparam int RADIUS_W = 24;
  localparam int TOL_W    = 16;
  localparam int DIST_W   = 26;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // coordinate units of 1/65536 degree
  localparam int FULL_TURN    = 23592960;
  localparam int HALF_TURN    = 11796480;
  localparam int QUARTER_TURN = 5898240;

  // cordic gain scaled by 2^62
  localparam logic [63:0] K62 = 64'd2800459870029452954;

  // register reset values
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd1630976;
  localparam logic [TOL_W-1:0]    TOL_RST    = 16'd1;

  // register index (address bit 2)
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TOL    = 1'b1;

  // atan(2^-i) by truncated series, i >= 1
  function automatic longint atan_series(input int i);
    longint s;
    s = 0;
    if (i <= 58)    s = s + (longint'(1) << (58 - i));
    if (3*i <= 58)  s = s - (longint'(1) << (58 - 3*i)) / 3;
    if (5*i <= 58)  s = s + (longint'(1) << (58 - 5*i)) / 5;
    if (7*i <= 58)  s = s - (longint'(1) << (58 - 7*i)) / 7;
    if (9*i <= 58)  s = s + (longint'(1) << (58 - 9*i)) / 9;
    if (11*i <= 58) s = s - (longint'(1) << (58 - 11*i)) / 11;
    if (13*i <= 58) s = s + (longint'(1) << (58 - 13*i)) / 13;
    if (15*i <= 58) s = s - (longint'(1) << (58 - 15*i)) / 15;
    if (17*i <= 58) s = s + (longint'(1) << (58 - 17*i)) / 17;
    if (19*i <= 58) s = s - (longint'(1) << (58 - 19*i)) / 19;
    if (21*i <= 58) s = s + (longint'(1) << (58 - 21*i)) / 21;
    if (23*i <= 58) s = s - (longint'(1) << (58 - 23*i)) / 23;
    if (25*i <= 58) s = s + (longint'(1) << (58 - 25*i)) / 25;
    if (27*i <= 58) s = s - (longint'(1) << (58 - 27*i)) / 27;
    if (29*i <= 58) s = s + (longint'(1) << (58 - 29*i)) / 29;
    if (31*i <= 58) s = s - (longint'(1) << (58 - 31*i)) / 31;
    if (33*i <= 58) s = s + (longint'(1) << (58 - 33*i)) / 33;
    if (35*i <= 58) s = s - (longint'(1) << (58 - 35*i)) / 35;
    if (37*i <= 58) s = s + (longint'(1) << (58 - 37*i)) / 37;
    if (39*i <= 58) s = s - (longint'(1) << (58 - 39*i)) / 39;
    if (41*i <= 58) s = s + (longint'(1) << (58 - 41*i)) / 41;
    if (43*i <= 58) s = s - (longint'(1) << (58 - 43*i)) / 43;
    if (45*i <= 58) s = s + (longint'(1) << (58 - 45*i)) / 45;
    if (47*i <= 58) s = s - (longint'(1) << (58 - 47*i)) / 47;
    if (49*i <= 58) s = s + (longint'(1) << (58 - 49*i)) / 49;
    if (51*i <= 58) s = s - (longint'(1) << (58 - 51*i)) / 51;
    if (53*i <= 58) s = s + (longint'(1) << (58 - 53*i)) / 53;
    if (55*i <= 58) s = s - (longint'(1) << (58 - 55*i)) / 55;
    if (57*i <= 58) s = s + (longint'(1) << (58 - 57*i)) / 57;
    return s;
  endfunction

  // atan(1) as atan(1/2) + atan(1/3)
  function automatic longint atan_one();
    longint s;
    longint p;
    s = 0;
    p = (longint'(1) << 58) / 3;
    s = s + p;      p = p / 9;
    s = s - p / 3;  p = p / 9;
    s = s + p / 5;  p = p / 9;
    s = s - p / 7;  p = p / 9;
    s = s + p / 9;  p = p / 9;
    s = s - p / 11; p = p / 9;
    s = s + p / 13; p = p / 9;
    s = s - p / 15; p = p / 9;
    s = s + p / 17; p = p / 9;
    s = s - p / 19; p = p / 9;
    s = s + p / 21; p = p / 9;
    s = s - p / 23; p = p / 9;
    s = s + p / 25; p = p / 9;
    s = s - p / 27; p = p / 9;
    s = s + p / 29; p = p / 9;
    s = s - p / 31; p = p / 9;
    s = s + p / 33; p = p / 9;
    s = s - p / 35; p = p / 9;
    s = s + p / 37; p = p / 9;
    s = s - p / 39;
    return atan_series(1) + s;
  endfunction

  function automatic longint atan_val(input int i);
    return (i == 0) ? atan_one() : atan_series(i);
  endfunction

  localparam longint ATAN_ONE = atan_one();
  localparam longint HALF_PI  = 2 * ATAN_ONE;
  // one coordinate unit in angle units
  localparam longint DEG_STEP = (4 * ATAN_ONE + HALF_TURN / 2) / HALF_TURN;

endpackage

### sv/gcd_mul.sv
// pipelined signed multiplier, rounds to nearest (ties away from zero) after a right shift
// uses no package; four register stages, all gated by en
`timescale 1ns / 1ps

module gcd_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SH = 30,
  parameter int PW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [PW-1:0] p
);

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int SW = AW + BW + 1;
  localparam logic [SW-1:0] RND = (SW'(1) << SH) >> 1;

  logic [AW-1:0]    ua_r, ua_nxt;
  logic [BW-1:0]    ub_r, ub_nxt;
  logic             neg1_r, neg2_r, neg3_r;
  logic [AW+BL-1:0] plo_r, plo_nxt;
  logic [AW+BH-1:0] phi_r, phi_nxt;
  logic [SW-1:0]    q_r, q_nxt;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    qn;
  logic signed [PW-1:0] p_r, p_nxt;

  // magnitudes, two partial products, sum and round, sign
  always_comb begin
    ua_nxt  = a[AW-1] ? AW'(-a) : AW'(a);
    ub_nxt  = b[BW-1] ? BW'(-b) : BW'(b);
    plo_nxt = (AW+BL)'(ua_r) * (AW+BL)'(ub_r[BL-1:0]);
    phi_nxt = (AW+BH)'(ua_r) * (AW+BH)'(ub_r[BW-1:BL]);
    sum     = SW'({phi_r, {BL{1'b0}}}) + SW'(plo_r) + RND;
    q_nxt   = sum >> SH;
    qn      = neg3_r ? (~q_r + SW'(1)) : q_r;
    p_nxt   = $signed(qn[PW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
      neg1_r <= a[AW-1] ^ b[BW-1];
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      neg2_r <= neg1_r;
      q_r    <= q_nxt;
      neg3_r <= neg2_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

### sv/gcd_cossin.sv
// cosine and sine of a coordinate angle: range reduction, scaling, rotation cordic
// depends on gcd_pkg
`timescale 1ns / 1ps

module gcd_cossin #(
  parameter int FRAC = gcd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [gcd_pkg::COORD_W-1:0] ang,
  output logic signed [FRAC+1:0]             cos_o,
  output logic signed [FRAC+1:0]             sin_o
);

  localparam int N  = FRAC + 2;
  localparam int XW = FRAC + 3;
  localparam int VW = FRAC + 2;
  localparam int ZW = gcd_pkg::ZW;
  localparam logic [63:0] KINIT =
    (gcd_pkg::K62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  localparam logic signed [26:0] FULL_S = 27'(gcd_pkg::FULL_TURN);
  localparam logic [24:0] Q1 = 25'(gcd_pkg::QUARTER_TURN);
  localparam logic [24:0] Q2 = 25'(2 * gcd_pkg::QUARTER_TURN);
  localparam logic [24:0] Q3 = 25'(3 * gcd_pkg::QUARTER_TURN);
  localparam logic [63:0] DS = 64'(gcd_pkg::DEG_STEP);
  localparam logic [19:0] DS_LO = DS[19:0];
  localparam logic [16:0] DS_HI = DS[36:20];
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [26:0] ang_x;
  logic signed [26:0] r1_r, r1_nxt;
  logic [24:0]        r2_r, r2_nxt;
  logic [1:0]         quad_r, quad_nxt, quad_m_r, quad_p;
  logic [22:0]        rem_r, rem_nxt;
  logic [42:0]        plo_r;
  logic [39:0]        phi_r;
  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [1:0]           q_r [N+1];
  logic signed [VW-1:0] cos_r, cos_nxt, sin_r, sin_nxt;

  // fold into one full turn
  always_comb begin
    ang_x = 27'(ang);
    if (ang_x < 0) begin
      r1_nxt = ang_x + FULL_S;
    end else if (ang_x >= FULL_S) begin
      r1_nxt = ang_x - FULL_S;
    end else begin
      r1_nxt = ang_x;
    end
    r2_nxt = (r1_r < 0) ? 25'(r1_r + FULL_S) : 25'(r1_r);
  end

  // quadrant and remainder
  always_comb begin
    if (r2_r >= Q3) begin
      quad_nxt = QUAD_3;
      rem_nxt  = 23'(r2_r - Q3);
    end else if (r2_r >= Q2) begin
      quad_nxt = QUAD_2;
      rem_nxt  = 23'(r2_r - Q2);
    end else if (r2_r >= Q1) begin
      quad_nxt = QUAD_1;
      rem_nxt  = 23'(r2_r - Q1);
    end else begin
      quad_nxt = QUAD_0;
      rem_nxt  = 23'(r2_r);
    end
  end

  // reduction and angle scaling stages
  always_ff @(posedge clk) begin
    if (en) begin
      r1_r     <= r1_nxt;
      r2_r     <= r2_nxt;
      quad_r   <= quad_nxt;
      rem_r    <= rem_nxt;
      plo_r    <= 43'(rem_r) * 43'(DS_LO);
      phi_r    <= 40'(rem_r) * 40'(DS_HI);
      quad_m_r <= quad_r;
      x_r[0]   <= XW'(KINIT);
      y_r[0]   <= '0;
      z_r[0]   <= ZW'({phi_r, 20'd0} + 60'(plo_r));
      q_r[0]   <= quad_m_r;
    end
  end

  // rotation stages, one per iteration
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = ZW'(gcd_pkg::atan_val(i));
    logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (!z_r[i][ZW-1]) begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - AT;
      end else begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + AT;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        q_r[i+1] <= q_r[i];
      end
    end
  end

  // quadrant correction
  always_comb begin
    quad_p = q_r[N];
    case (quad_p)
      QUAD_0: begin
        cos_nxt = VW'(x_r[N]);
        sin_nxt = VW'(y_r[N]);
      end
      QUAD_1: begin
        cos_nxt = VW'(-y_r[N]);
        sin_nxt = VW'(x_r[N]);
      end
      QUAD_2: begin
        cos_nxt = VW'(-x_r[N]);
        sin_nxt = VW'(-y_r[N]);
      end
      default: begin
        cos_nxt = VW'(y_r[N]);
        sin_nxt = VW'(-x_r[N]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### sv/gcd_point.sv
// unit vector of one point from latitude and longitude
// depends on gcd_pkg, gcd_cossin, gcd_mul
`timescale 1ns / 1ps

module gcd_point #(
  parameter int FRAC = gcd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [gcd_pkg::LAT_W-1:0]   lat,
  input  logic signed [gcd_pkg::COORD_W-1:0] lon,
  output logic signed [FRAC+1:0]             v0,
  output logic signed [FRAC+1:0]             v1,
  output logic signed [FRAC+1:0]             v2
);

  localparam int VW = FRAC + 2;

  logic signed [gcd_pkg::COORD_W-1:0] lat_x;
  logic signed [VW-1:0] cl, sl, co, so;
  logic signed [VW-1:0] sl_r [4];

  assign lat_x = gcd_pkg::COORD_W'(lat);

  gcd_cossin #(.FRAC(FRAC)) u_lat (
    .clk(clk), .en(en), .ang(lat_x), .cos_o(cl), .sin_o(sl)
  );

  gcd_cossin #(.FRAC(FRAC)) u_lon (
    .clk(clk), .en(en), .ang(lon), .cos_o(co), .sin_o(so)
  );

  // x and y components
  gcd_mul #(.AW(VW), .BW(VW), .SH(FRAC), .PW(VW)) u_mx (
    .clk(clk), .en(en), .a(cl), .b(co), .p(v0)
  );

  gcd_mul #(.AW(VW), .BW(VW), .SH(FRAC), .PW(VW)) u_my (
    .clk(clk), .en(en), .a(cl), .b(so), .p(v1)
  );

  // z component aligned with the products
  always_ff @(posedge clk) begin
    if (en) begin
      sl_r[0] <= sl;
      sl_r[1] <= sl_r[0];
      sl_r[2] <= sl_r[1];
      sl_r[3] <= sl_r[2];
    end
  end

  assign v2 = sl_r[3];

endmodule

### sv/gcd_angle.sv
// central angle by cross and dot product, square root and vectoring cordic, then scaling
// depends on gcd_pkg, gcd_mul
`timescale 1ns / 1ps

module gcd_angle #(
  parameter int FRAC = gcd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [FRAC+1:0]              a0,
  input  logic signed [FRAC+1:0]              a1,
  input  logic signed [FRAC+1:0]              a2,
  input  logic signed [FRAC+1:0]              b0,
  input  logic signed [FRAC+1:0]              b1,
  input  logic signed [FRAC+1:0]              b2,
  input  logic [gcd_pkg::RADIUS_W-1:0]        radius,
  output logic [gcd_pkg::DIST_W-1:0]          dist_o
);

  localparam int N    = FRAC + 2;
  localparam int VW   = FRAC + 2;
  localparam int CW   = FRAC + 3;
  localparam int SQW  = 2 * FRAC + 4;
  localparam int RW   = FRAC + 2;
  localparam int REMW = RW + 3;
  localparam int VXW  = FRAC + 6;
  localparam int ZW   = gcd_pkg::ZW;
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(gcd_pkg::HALF_PI);

  logic signed [VW-1:0]  ma [9];
  logic signed [VW-1:0]  mb [9];
  logic signed [CW-1:0]  pr [9];
  logic signed [CW-1:0]  c_r [3];
  logic signed [CW-1:0]  dot_r;
  logic signed [CW-1:0]  dd_r [4];
  logic signed [SQW-1:0] sq [3];
  logic [REMW-1:0]       rem_r [RW+1];
  logic [RW-1:0]         root_r [RW+1];
  logic [SQW-1:0]        rad_r [RW+1];
  logic signed [CW-1:0]  dq_r [RW+1];
  logic signed [VXW-1:0] vx_r [N+1];
  logic signed [VXW-1:0] vy_r [N+1];
  logic signed [ZW-1:0]  vz_r [N+1];
  logic                  zf_r [N+1];
  logic signed [VXW-1:0] nrm_x, dot_x;
  logic signed [ZW-1:0]  ang_r;
  logic signed [gcd_pkg::RADIUS_W:0] rad_s;
  logic signed [gcd_pkg::DIST_W:0]   dist_s;

  // operand pairs for cross and dot products
  always_comb begin
    ma[0] = a1; mb[0] = b2;
    ma[1] = b1; mb[1] = a2;
    ma[2] = b0; mb[2] = a2;
    ma[3] = a0; mb[3] = b2;
    ma[4] = a0; mb[4] = b1;
    ma[5] = b0; mb[5] = a1;
    ma[6] = a0; mb[6] = b0;
    ma[7] = a1; mb[7] = b1;
    ma[8] = a2; mb[8] = b2;
  end

  for (genvar g = 0; g < 9; g++) begin : g_prod
    gcd_mul #(.AW(VW), .BW(VW), .SH(FRAC), .PW(CW)) u_pm (
      .clk(clk), .en(en), .a(ma[g]), .b(mb[g]), .p(pr[g])
    );
  end

  // cross product components and dot product
  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= pr[0] - pr[1];
      c_r[1] <= pr[2] - pr[3];
      c_r[2] <= pr[4] - pr[5];
      dot_r  <= pr[6] + pr[7] + pr[8];
      dd_r[0] <= dot_r;
      dd_r[1] <= dd_r[0];
      dd_r[2] <= dd_r[1];
      dd_r[3] <= dd_r[2];
    end
  end

  // exact squares of the cross components
  for (genvar g = 0; g < 3; g++) begin : g_sq
    gcd_mul #(.AW(CW), .BW(CW), .SH(0), .PW(SQW)) u_sq (
      .clk(clk), .en(en), .a(c_r[g]), .b(c_r[g]), .p(sq[g])
    );
  end

  // sum of squares starts the root pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= $unsigned(sq[0] + sq[1] + sq[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      dq_r[0]   <= dd_r[3];
    end
  end

  // floor square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_t, trial, rem_nxt;
    logic [RW-1:0]   root_nxt;

    always_comb begin
      rem_t = {rem_r[k][REMW-3:0], rad_r[k][SQW-1:SQW-2]};
      trial = REMW'({root_r[k], 2'b01});
      if (rem_t >= trial) begin
        rem_nxt  = rem_t - trial;
        root_nxt = {root_r[k][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t;
        root_nxt = {root_r[k][RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        rad_r[k+1]  <= {rad_r[k][SQW-3:0], 2'b00};
        dq_r[k+1]   <= dq_r[k];
      end
    end
  end

  // vectoring start: rotate into the right half plane when the dot product is negative
  always_comb begin
    nrm_x = VXW'($signed({1'b0, root_r[RW]}));
    dot_x = VXW'(dq_r[RW]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (root_r[RW] == '0) && (dq_r[RW] == '0);
      if (dq_r[RW] < 0) begin
        vx_r[0] <= nrm_x;
        vy_r[0] <= -dot_x;
        vz_r[0] <= HALF_PI;
      end else begin
        vx_r[0] <= dot_x;
        vy_r[0] <= nrm_x;
        vz_r[0] <= '0;
      end
    end
  end

  // vectoring stages, one per iteration
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [ZW-1:0] AT = ZW'(gcd_pkg::atan_val(i));
    logic signed [VXW-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ZW-1:0]  z_nxt;

    always_comb begin
      xs = vx_r[i] >>> i;
      ys = vy_r[i] >>> i;
      if (!vy_r[i][VXW-1]) begin
        x_nxt = vx_r[i] + ys;
        y_nxt = vy_r[i] - xs;
        z_nxt = vz_r[i] + AT;
      end else begin
        x_nxt = vx_r[i] - ys;
        y_nxt = vy_r[i] + xs;
        z_nxt = vz_r[i] - AT;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vx_r[i+1] <= x_nxt;
        vy_r[i+1] <= y_nxt;
        vz_r[i+1] <= z_nxt;
        zf_r[i+1] <= zf_r[i];
      end
    end
  end

  // degenerate vectors and negative residue give zero angle
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= (zf_r[N] || vz_r[N][ZW-1]) ? '0 : vz_r[N];
    end
  end

  // angle times radius
  assign rad_s = $signed({1'b0, radius});

  gcd_mul #(
    .AW(ZW), .BW(gcd_pkg::RADIUS_W + 1), .SH(gcd_pkg::ANG_FRAC), .PW(gcd_pkg::DIST_W + 1)
  ) u_scale (
    .clk(clk), .en(en), .a(ang_r), .b(rad_s), .p(dist_s)
  );

  assign dist_o = dist_s[gcd_pkg::DIST_W-1:0];

endmodule

### sv/great_circle_distance.sv
// top level of the great-circle distance pipeline with its register port
// depends on gcd_pkg, gcd_point, gcd_angle, gcd_mul, gcd_cossin, assert_macros.svh
`timescale 1ns / 1ps
//
// Usage:
// Input items carry lat_a, lon_a, lat_b, lon_b in 1/65536 degree and are taken
// with in_valid/in_ready; each gives exactly one out_distance item (1/256 km)
// on out_valid/out_ready, in order. One item can enter every cycle unless the
// pipeline holds. It is built from two chains of ANGLE_FRAC_BITS + 2 cordic
// stages (point rotation, then vectoring) with a square-root pipeline of
// ANGLE_FRAC_BITS + 2 stages between them.
// When out_valid is high and out_ready is low the whole pipeline holds and
// in_ready drops in the same cycle; nothing is lost or repeated.
// Registers (write over the APB port): sphere_radius at 0x0, zero_tolerance
// at 0x4. Write them only while no item is in flight.
// Synchronous active-low reset empties the pipeline and restores the radius
// (6371 km) and tolerance (1 unit) defaults.
//
`include "assert_macros.svh"

module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_lat_a,
  input  logic signed [gcd_pkg::COORD_W-1:0] in_lon_a,
  input  logic signed [gcd_pkg::LAT_W-1:0]   in_lat_b,
  input  logic signed [gcd_pkg::COORD_W-1:0] in_lon_b,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gcd_pkg::DIST_W-1:0]         out_distance,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gcd_pkg::APB_AW-1:0]         paddr,
  input  logic [gcd_pkg::APB_DW-1:0]         pwdata,
  output logic [gcd_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int N  = F + 2;
  localparam int RW = F + 2;
  localparam int LP = N + 10;
  localparam int LA = RW + N + 16;
  localparam int L  = LP + LA;

  logic                            pipe_en;
  logic [L-1:0]                    v_r;
  logic [L-1:0]                    near_r;
  logic                            near_nxt;
  logic signed [24:0]              dl;
  logic signed [26:0]              dn;
  logic [24:0]                     dl_abs;
  logic [26:0]                     dn_abs;
  logic [gcd_pkg::RADIUS_W-1:0]    radius_r;
  logic [gcd_pkg::TOL_W-1:0]       tol_r;
  logic                            wr_en;
  logic signed [F+1:0]             a0, a1, a2, b0, b1, b2;
  logic [gcd_pkg::DIST_W-1:0]      ang_dist;
  logic                            out_valid_r;
  logic [gcd_pkg::DIST_W-1:0]      out_distance_r;

  // whole pipeline moves unless a finished item is waiting
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcd_pkg::RADIUS_RST;
      tol_r    <= gcd_pkg::TOL_RST;
    end else if (wr_en) begin
      case (paddr[2])
        gcd_pkg::REG_RADIUS: radius_r <= pwdata[gcd_pkg::RADIUS_W-1:0];
        gcd_pkg::REG_TOL:    tol_r    <= pwdata[gcd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gcd_pkg::REG_RADIUS: prdata = gcd_pkg::APB_DW'(radius_r);
      gcd_pkg::REG_TOL:    prdata = gcd_pkg::APB_DW'(tol_r);
      default:             prdata = '0;
    endcase
  end

  // near-point check on raw coordinate differences
  always_comb begin
    dl       = 25'(in_lat_b) - 25'(in_lat_a);
    dn       = 27'(in_lon_b) - 27'(in_lon_a);
    dl_abs   = dl[24] ? 25'(-dl) : 25'(dl);
    dn_abs   = dn[26] ? 27'(-dn) : 27'(dn);
    near_nxt = (dl_abs < 25'(tol_r)) && (dn_abs < 27'(tol_r));
  end

  // valid and near flags travel alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      near_r <= {near_r[L-2:0], near_nxt};
    end
  end

  // unit vectors of both points
  gcd_point #(.FRAC(F)) u_pa (
    .clk(clk), .en(pipe_en), .lat(in_lat_a), .lon(in_lon_a),
    .v0(a0), .v1(a1), .v2(a2)
  );

  gcd_point #(.FRAC(F)) u_pb (
    .clk(clk), .en(pipe_en), .lat(in_lat_b), .lon(in_lon_b),
    .v0(b0), .v1(b1), .v2(b2)
  );

  // central angle and distance
  gcd_angle #(.FRAC(F)) u_ang (
    .clk(clk), .en(pipe_en),
    .a0(a0), .a1(a1), .a2(a2), .b0(b0), .b1(b1), .b2(b2),
    .radius(radius_r), .dist_o(ang_dist)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= v_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_distance_r <= near_r[L-1] ? '0 : ang_dist;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  // checks
  `GCD_ASSERT(a_stall_blocks_input, (out_valid_r && !out_ready) |-> !in_ready, "stall leak")
  `GCD_ASSERT(a_tail_holds, (v_r[L-1] && !pipe_en) |=> v_r[L-1], "tail lost")
  `GCD_ASSERT_NORST(a_reset_clears, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

### verif/great_circle_distance_test.sv
// testbench for the great-circle distance pipeline: random and directed point pairs
// checked against an in-bench fixed-point cordic predictor; depends on gcd_pkg and the rtl
`timescale 1ns / 1ps

module great_circle_distance_test;

  localparam int FB      = gcd_pkg::ANGLE_FRAC_BITS;
  localparam int AFRAC   = 58;
  localparam int NITER   = (FB + 2 > 60) ? 60 : FB + 2;
  localparam int LATENCY = 3 * FB + 33;
  localparam int WD_LIMIT = 4000;
  localparam logic [gcd_pkg::APB_AW-1:0] ADDR_RADIUS = {gcd_pkg::REG_RADIUS, 2'b00};
  localparam logic [gcd_pkg::APB_AW-1:0] ADDR_TOL    = {gcd_pkg::REG_TOL, 2'b00};

  typedef struct {
    logic signed [gcd_pkg::LAT_W-1:0]   lat_a;
    logic signed [gcd_pkg::COORD_W-1:0] lon_a;
    logic signed [gcd_pkg::LAT_W-1:0]   lat_b;
    logic signed [gcd_pkg::COORD_W-1:0] lon_b;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [gcd_pkg::LAT_W-1:0]   in_lat_a = '0;
  logic signed [gcd_pkg::COORD_W-1:0] in_lon_a = '0;
  logic signed [gcd_pkg::LAT_W-1:0]   in_lat_b = '0;
  logic signed [gcd_pkg::COORD_W-1:0] in_lon_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gcd_pkg::DIST_W-1:0] out_distance;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [gcd_pkg::APB_AW-1:0] paddr = '0;
  logic [gcd_pkg::APB_DW-1:0] pwdata = '0;
  logic [gcd_pkg::APB_DW-1:0] prdata;
  logic pready;

  great_circle_distance u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_lat_a, .in_lon_a, .in_lat_b, .in_lon_b,
    .out_valid, .out_ready, .out_distance,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  // predictor copies of the registers and tables
  longint atan_tab [0:59];
  longint step_per_unit;
  longint half_pi_ang;
  longint cur_radius = 1630976;
  longint cur_tol = 1;

  pair_t pending_pairs [$];
  logic [gcd_pkg::DIST_W-1:0] expected_dist [$];
  bit failed = 0;
  bit no_idle = 0;

  // arctangent table by truncated series, atan(1) split as atan(1/2) + atan(1/3)
  task automatic build_atan();
    longint s, t, p;
    int k;
    for (int i = 1; i < 60; i++) begin
      s = 0;
      for (k = 0; (2 * k + 1) * i <= AFRAC; k++) begin
        t = (longint'(1) << (AFRAC - (2 * k + 1) * i)) / (2 * k + 1);
        s = (k & 1) ? s - t : s + t;
      end
      atan_tab[i] = s;
    end
    s = 0;
    p = (longint'(1) << AFRAC) / 3;
    for (k = 0; p > 0; k++) begin
      t = p / (2 * k + 1);
      s = (k & 1) ? s - t : s + t;
      p = p / 9;
    end
    atan_tab[0] = atan_tab[1] + s;
    half_pi_ang = 2 * atan_tab[0];
    step_per_unit = (4 * atan_tab[0] + gcd_pkg::HALF_TURN / 2) / gcd_pkg::HALF_TURN;
  endtask

  // round(a*b / 2^s), ties away from zero, saturating
  function automatic longint round_mul(longint a, longint b, int s);
    longint aa, bb;
    logic [127:0] pr;
    logic neg;
    neg = (a < 0) != (b < 0);
    aa = a < 0 ? -a : a;
    bb = b < 0 ? -b : b;
    pr = {64'd0, aa} * {64'd0, bb} + (128'd1 << (s - 1));
    pr = pr >> s;
    if (pr > 128'h7fff_ffff_ffff_ffff) pr = 128'h7fff_ffff_ffff_ffff;
    return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  function automatic logic [127:0] square_of(longint v);
    longint a;
    a = v < 0 ? -v : v;
    return {64'd0, a} * {64'd0, a};
  endfunction

  function automatic longint floor_sqrt(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return longint'(r);
  endfunction

  // rotation cordic on the angle reduced into one quadrant
  task automatic rotate_unit(input longint d, output longint c, output longint s);
    longint m, q, z, x, y, xs, ys;
    logic [63:0] k0;
    m = d % gcd_pkg::FULL_TURN;
    if (m < 0) m += gcd_pkg::FULL_TURN;
    q = m / gcd_pkg::QUARTER_TURN;
    z = (m - q * gcd_pkg::QUARTER_TURN) * step_per_unit;
    k0 = (gcd_pkg::K62 + (64'd1 << (61 - FB))) >> (62 - FB);
    x = longint'(k0);
    y = 0;
    for (int i = 0; i < NITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic point_vector(input longint lat, input longint lon,
                              output longint vx, output longint vy, output longint vz);
    longint cl, sl, co, so;
    rotate_unit(lat, cl, sl);
    rotate_unit(lon, co, so);
    vx = round_mul(cl, co, FB);
    vy = round_mul(cl, so, FB);
    vz = sl;
  endtask

  // vectoring cordic: atan2(nrm, dot)
  function automatic longint arc_angle(longint nrm, longint dot);
    longint x, y, z, xs, ys;
    if (nrm == 0 && dot == 0) return 0;
    x = dot; y = nrm; z = 0;
    if (x < 0) begin
      x = nrm; y = -dot; z = half_pi_ang;
    end
    for (int i = 0; i < NITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  task automatic predict_distance(input pair_t p, output logic [gcd_pkg::DIST_W-1:0] res);
    longint la, oa, lb, ob, dl, dn;
    longint ax, ay, az, bx, by, bz, c0, c1, c2, dot, ang, dd;
    la = p.lat_a; oa = p.lon_a; lb = p.lat_b; ob = p.lon_b;
    dl = lb - la; dn = ob - oa;
    if (dl < 0) dl = -dl;
    if (dn < 0) dn = -dn;
    if (dl < cur_tol && dn < cur_tol) begin
      res = '0;
      return;
    end
    point_vector(la, oa, ax, ay, az);
    point_vector(lb, ob, bx, by, bz);
    c0 = round_mul(ay, bz, FB) - round_mul(by, az, FB);
    c1 = round_mul(bx, az, FB) - round_mul(ax, bz, FB);
    c2 = round_mul(ax, by, FB) - round_mul(bx, ay, FB);
    dot = round_mul(ax, bx, FB) + round_mul(ay, by, FB) + round_mul(az, bz, FB);
    ang = arc_angle(floor_sqrt(square_of(c0) + square_of(c1) + square_of(c2)), dot);
    dd = round_mul(ang, cur_radius, AFRAC);
    if (dd > 64'h3ffffff) dd = 64'h3ffffff;
    res = dd[gcd_pkg::DIST_W-1:0];
  endtask

  // input driver: one item from the queue per handshake, random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    logic [gcd_pkg::DIST_W-1:0] d;
    logic busy;
    pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_distance('{in_lat_a, in_lon_a, in_lat_b, in_lon_b}, d);
        expected_dist.push_back(d);
        busy = 1'b0;
        send_gap = no_idle ? 0 : int'($urandom_range(0, 3));
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          nxt = pending_pairs.pop_front();
          in_valid <= 1'b1;
          in_lat_a <= nxt.lat_a;
          in_lon_a <= nxt.lon_a;
          in_lat_b <= nxt.lat_b;
          in_lon_b <= nxt.lon_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int recv_stall = 0;
  always @(posedge clk) begin
    logic [gcd_pkg::DIST_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dist.size() == 0) begin
          $error("unexpected item: distance %0d", out_distance);
          failed = 1;
        end else begin
          want = expected_dist.pop_front();
          if (out_distance !== want) begin
            $error("distance mismatch: expected %0d actual %0d", want, out_distance);
            failed = 1;
          end
        end
        recv_stall = no_idle ? 0 : int'($urandom_range(0, 3));
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [gcd_pkg::APB_AW-1:0] addr,
                           input logic [gcd_pkg::APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) cur_radius = longint'(data[gcd_pkg::RADIUS_W-1:0]);
    else cur_tol = longint'(data[gcd_pkg::TOL_W-1:0]);
  endtask

  // wait until every item is sent and answered, then let the pipe empty
  task automatic drain();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_valid || expected_dist.size() != 0);
    repeat (LATENCY + 20) @(negedge clk);
  endtask

  task automatic add_pair(input int la, input int oa, input int lb, input int ob);
    pending_pairs.push_back('{gcd_pkg::LAT_W'(la), gcd_pkg::COORD_W'(oa),
                              gcd_pkg::LAT_W'(lb), gcd_pkg::COORD_W'(ob)});
  endtask

  function automatic int rand_span(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // mostly in-range pairs, some near pairs, some raw full-width bits
  task automatic add_random(input int count);
    int la, oa, lb, ob, sp;
    logic [31:0] r0, r1, r2, r3;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin
          r0 = $urandom; r1 = $urandom; r2 = $urandom; r3 = $urandom;
          pending_pairs.push_back('{r0[gcd_pkg::LAT_W-1:0], r1[gcd_pkg::COORD_W-1:0],
                                    r2[gcd_pkg::LAT_W-1:0], r3[gcd_pkg::COORD_W-1:0]});
        end
        1, 2: begin
          sp = (cur_tol > 60000) ? 65537 : int'(cur_tol) + 2;
          la = rand_span(-gcd_pkg::QUARTER_TURN, gcd_pkg::QUARTER_TURN);
          oa = rand_span(-gcd_pkg::FULL_TURN, gcd_pkg::FULL_TURN);
          add_pair(la, oa, la + rand_span(-sp, sp), oa + rand_span(-sp, sp));
        end
        default: add_pair(rand_span(-gcd_pkg::QUARTER_TURN, gcd_pkg::QUARTER_TURN),
                          rand_span(-gcd_pkg::FULL_TURN, gcd_pkg::FULL_TURN),
                          rand_span(-gcd_pkg::QUARTER_TURN, gcd_pkg::QUARTER_TURN),
                          rand_span(-gcd_pkg::FULL_TURN, gcd_pkg::FULL_TURN));
      endcase
    end
  endtask

  task automatic add_directed();
    int qt, ht, ft;
    qt = gcd_pkg::QUARTER_TURN;
    ht = gcd_pkg::HALF_TURN;
    ft = gcd_pkg::FULL_TURN;
    add_pair(0, 0, 0, 0);                                   // same point
    add_pair(0, 0, 0, ht);                                  // antipodal on equator
    add_pair(qt, 0, -qt, 0);                                // pole to pole
    add_pair(qt, 0, qt, ft);                                // same pole, full turn
    add_pair(-qt, -ft, qt, ft);
    add_pair(qt, -ft, -qt, ft);
    add_pair(0, 0, 0, 1);                                   // one unit apart
    add_pair(0, 0, 1, 1);
    add_pair(100, 200, 100, 200);
    add_pair(0, 0, 0, qt);
    add_pair(0, -ht, 0, ht);                                // same meridian, wrapped
    // out-of-range coordinates, full-width extremes
    add_pair(-(1 << 23), -(1 << 25), (1 << 23) - 1, (1 << 25) - 1);
    add_pair((1 << 23) - 1, (1 << 25) - 1, -(1 << 23), -(1 << 25));
    add_pair(-1, -1, 0, 0);
    add_pair(7000000, 30000000, -7000000, -30000000);
    add_pair(2949120, 1000, -2949120, ht + 1000);           // antipodal
    add_pair(2949120, 1000, 2949121, 1000);
    add_pair(123456, -654321, -123456, 654321);
    add_pair(qt - 1, 5, qt, 5);
    add_pair(-qt, 0, -qt + 65535, 65535);
  endtask

  task automatic run_phase(input logic [gcd_pkg::APB_DW-1:0] radius,
                           input logic [gcd_pkg::APB_DW-1:0] tol, input int count,
                           input bit quiet);
    drain();
    reg_write(ADDR_RADIUS, radius);
    reg_write(ADDR_TOL, tol);
    no_idle = quiet;
    add_directed();
    add_random(count);
  endtask

  initial begin
    build_atan();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // defaults from reset first
    add_directed();
    add_random(110);
    run_phase(32'hffffff, 32'd0, 110, 1'b0);
    run_phase(32'd1, 32'hffff, 90, 1'b1);
    run_phase($urandom_range(1, 24'hffffff), $urandom_range(0, 300), 110, 1'b0);
    run_phase(32'd1630976, 32'd1, 110, 1'b0);
    drain();
    if (!failed && expected_dist.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/gcd_pkg.sv
sv/gcd_mul.sv
sv/gcd_cossin.sv
sv/gcd_point.sv
sv/gcd_angle.sv
sv/great_circle_distance.sv
verif/great_circle_distance_test.sv
